[hdl/lru_kv_pkg.sv]
// Shared types and constants for the LRU key-value cache.
// Used by lru_kv_cfg, lru_kv_store and lru_key_value_cache; no dependencies.
`default_nettype none

package lru_kv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int AGE_W = IDX_W;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int DATA_W = 32;
  localparam int CAP_W = 5;
  localparam int ADDR_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Word index of the capacity register in the configuration space.
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic              fire;
    logic              command;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] read_value;
  } resp_t;

endpackage

`default_nettype wire

[hdl/lru_key_value_cache.sv]
// Top level of the fully associative LRU key-value cache.
// Instantiates lru_kv_cfg and lru_kv_store; uses lru_kv_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall, command, key, value) carries one get or
//   put per transfer. Output channel (out_valid/out_stall, hit, read_value)
//   carries one result per get; a put yields no result.
//   An accepted item is held in an input register; there it is looked up
//   against all entries and updates the recency ranks, and a get result is
//   captured in the output register at the same edge as the rank update.
//   Throughput is one item per cycle unless a get waits on a stalled output;
//   the entry store does the tag compare and rank update as each item advances.
//   When the receiver stalls, the result holds in the output register; the
//   input register still drains puts, and a pending get waits, which raises
//   in_stall.
//   Reset empties the store and sets capacity to 16. The capacity register is
//   at byte address 0 of the APB port and may be written only while idle.
`default_nettype none

module lru_key_value_cache (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lru_kv_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          command,
  input  wire logic signed [31:0]            key,
  input  wire logic signed [31:0]            value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               hit,
  output logic signed [31:0]                 read_value
);

  logic                              held_valid;
  logic                              held_command;
  logic [lru_kv_pkg::DATA_W-1:0]     held_key;
  logic [lru_kv_pkg::DATA_W-1:0]     held_value;
  logic                              advance;
  logic                              out_free;
  logic                              in_take;
  logic [lru_kv_pkg::CNT_W-1:0]      eff_capacity;
  lru_kv_pkg::req_t                  req;
  lru_kv_pkg::resp_t                 resp;

  assign pready = 1'b1;

  lru_kv_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .eff_capacity (eff_capacity)
  );

  assign out_free = !out_valid || !out_stall;
  // A put needs no output slot; a get waits for the output register.
  assign advance  = held_valid &&
                    ((held_command == lru_kv_pkg::CMD_PUT) || out_free);
  assign in_stall = held_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    req.fire    = advance;
    req.command = held_command;
    req.key     = held_key;
    req.value   = held_value;
  end

  lru_kv_store u_store (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .eff_capacity (eff_capacity),
    .resp         (resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      held_command <= command;
      held_key     <= key;
      held_value   <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (held_command == lru_kv_pkg::CMD_GET)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (held_command == lru_kv_pkg::CMD_GET)) begin
      hit        <= resp.hit;
      read_value <= resp.read_value;
    end
  end

  a_get_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (advance && (held_command == lru_kv_pkg::CMD_GET)) |-> out_free)
    else $error("get result would overwrite a pending result");

  a_miss_all_ones: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (read_value == -32'sd1))
    else $error("miss result is not all ones");

endmodule

`default_nettype wire

[hdl/lru_kv_cfg.sv]
// APB-style configuration register for the LRU key-value cache.
// Holds the capacity register and derives the clamped capacity; uses lru_kv_pkg.
`default_nettype none

module lru_kv_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lru_kv_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic [lru_kv_pkg::CNT_W-1:0]           eff_capacity
);

  logic [lru_kv_pkg::CAP_W-1:0] capacity;
  logic                         sel_cap;

  // Byte offset bits are ignored; the word index selects the register.
  assign sel_cap = (paddr[2] == lru_kv_pkg::REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lru_kv_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && sel_cap) begin
      capacity <= pwdata[lru_kv_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_cap) begin
      prdata = 32'(capacity);
    end
  end

  // Zero behaves as one entry; values above the store size saturate.
  always_comb begin
    if (capacity == '0) begin
      eff_capacity = lru_kv_pkg::CNT_W'(1);
    end else if (32'(capacity) > 32'(lru_kv_pkg::MAX_ENTRIES)) begin
      eff_capacity = lru_kv_pkg::CNT_W'(lru_kv_pkg::MAX_ENTRIES);
    end else begin
      eff_capacity = lru_kv_pkg::CNT_W'(capacity);
    end
  end

endmodule

`default_nettype wire

[hdl/lru_kv_store.sv]
// Entry storage, parallel tag compare and recency-rank update of the cache.
// Each request is looked up combinationally and the entry state is registered; uses lru_kv_pkg.
`default_nettype none

module lru_kv_store (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire lru_kv_pkg::req_t                  req,
  input  wire logic [lru_kv_pkg::CNT_W-1:0]      eff_capacity,
  output lru_kv_pkg::resp_t                      resp
);

  localparam int N = lru_kv_pkg::MAX_ENTRIES;

  logic [lru_kv_pkg::DATA_W-1:0] entry_key   [N];
  logic [lru_kv_pkg::DATA_W-1:0] entry_value [N];
  logic [N-1:0]                  entry_valid;
  logic [lru_kv_pkg::AGE_W-1:0]  entry_age   [N];
  logic [lru_kv_pkg::CNT_W-1:0]  valid_count;

  logic [N-1:0]                  match;
  logic                          hit;
  logic [lru_kv_pkg::IDX_W-1:0]  hit_idx;
  logic                          free_any;
  logic [lru_kv_pkg::IDX_W-1:0]  free_idx;
  logic [lru_kv_pkg::IDX_W-1:0]  oldest_idx;
  logic [lru_kv_pkg::AGE_W-1:0]  oldest_age;
  logic                          room;
  logic                          touch;
  logic                          insert;
  logic [lru_kv_pkg::IDX_W-1:0]  target;
  logic [lru_kv_pkg::AGE_W-1:0]  target_age;
  logic                          age_all;
  logic                          write_data;

  assign oldest_age = lru_kv_pkg::AGE_W'(valid_count - lru_kv_pkg::CNT_W'(1));

  // Tag compare and the slot searches. Valid ranks are always a permutation of
  // 0 .. valid_count-1, so the least recent entry is the one with the top rank.
  always_comb begin
    hit_idx    = '0;
    free_idx   = '0;
    oldest_idx = '0;
    free_any   = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      match[i] = entry_valid[i] && (entry_key[i] == req.key);
      if (match[i]) begin
        hit_idx = lru_kv_pkg::IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        free_idx = lru_kv_pkg::IDX_W'(i);
        free_any = 1'b1;
      end
      if (entry_valid[i] && (entry_age[i] == oldest_age)) begin
        oldest_idx = lru_kv_pkg::IDX_W'(i);
      end
    end
  end

  assign hit  = |match;
  assign room = (valid_count < eff_capacity) && free_any;

  always_comb begin
    touch      = 1'b0;
    insert     = 1'b0;
    write_data = 1'b0;
    age_all    = 1'b0;
    target     = hit_idx;
    if (req.fire) begin
      if (hit) begin
        touch      = 1'b1;
        write_data = (req.command == lru_kv_pkg::CMD_PUT);
      end else if (req.command == lru_kv_pkg::CMD_PUT) begin
        // New key: every other valid entry becomes one step older.
        touch      = 1'b1;
        write_data = 1'b1;
        age_all    = 1'b1;
        insert     = room;
        target     = room ? free_idx : oldest_idx;
      end
    end
  end

  assign target_age = entry_age[target];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      valid_count <= '0;
      for (int i = 0; i < N; i++) begin
        entry_age[i] <= '0;
      end
    end else if (touch) begin
      for (int i = 0; i < N; i++) begin
        if (lru_kv_pkg::IDX_W'(i) == target) begin
          entry_age[i] <= '0;
        end else if (entry_valid[i] && (age_all || (entry_age[i] < target_age))) begin
          entry_age[i] <= entry_age[i] + lru_kv_pkg::AGE_W'(1);
        end
      end
      if (insert) begin
        entry_valid[target] <= 1'b1;
        valid_count         <= valid_count + lru_kv_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write_data) begin
      entry_key[target]   <= req.key;
      entry_value[target] <= req.value;
    end
  end

  always_comb begin
    resp.hit        = hit;
    resp.read_value = hit ? entry_value[hit_idx] : '1;
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(valid_count))
    else $error("valid entry count disagrees with valid bits");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(valid_count) <= N)
    else $error("valid entry count exceeds store size");

  a_touched_is_newest: assert property (@(posedge clk) disable iff (rst)
    touch |=> (entry_valid[$past(target)] && (entry_age[$past(target)] == '0)))
    else $error("touched entry is not valid and most recent");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    insert |=> (valid_count == $past(valid_count) + lru_kv_pkg::CNT_W'(1)))
    else $error("insert did not grow the valid entry count");

endmodule

`default_nettype wire

[tb/tb_lru_key_value_cache.sv]
// Self-checking testbench for lru_key_value_cache: directed and random get/put traffic
// under several capacities and idle patterns, checked against an in-bench LRU predictor.
// Depends on lru_kv_pkg and the lru_key_value_cache RTL.
module tb_lru_key_value_cache;

  localparam int NSLOT = lru_kv_pkg::MAX_ENTRIES;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 124;
  localparam int HOLD_CYCLES = 300;
  localparam logic [lru_kv_pkg::ADDR_W-1:0] CAP_ADDR =
    lru_kv_pkg::ADDR_W'({lru_kv_pkg::REG_CAPACITY, 2'b00});

  typedef struct {
    logic        command;
    logic [31:0] key;
    logic [31:0] value;
  } cache_op_t;

  typedef struct {
    logic        hit;
    logic [31:0] read_value;
  } lookup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lru_kv_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = lru_kv_pkg::CMD_GET;
  logic signed [31:0] key = '0;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic signed [31:0] read_value;

  lru_key_value_cache u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .key(key), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .read_value(read_value)
  );

  // Predictor state: a shadow of the entry store and the capacity register.
  logic [31:0] slot_key [NSLOT];
  logic [31:0] slot_val [NSLOT];
  logic        slot_used [NSLOT];
  int unsigned slot_rank [NSLOT];
  int unsigned used_count = 0;
  logic [lru_kv_pkg::CAP_W-1:0] cap_reg = lru_kv_pkg::CAP_RESET;

  cache_op_t access_q [$];
  lookup_t   pending_reads [$];
  int queued_cnt = 0;
  int accepted_cnt = 0;
  int err_cnt = 0;
  int get_cnt = 0;
  int hit_cnt = 0;
  int put_cnt = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_cnt = 0;

  function automatic int find_slot(logic [31:0] k);
    for (int i = 0; i < NSLOT; i++)
      if (slot_used[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  // Move slot s to rank 0; every valid entry that was more recent ages by one.
  function automatic void promote(int s);
    int unsigned r;
    r = slot_rank[s];
    for (int i = 0; i < NSLOT; i++)
      if (i != s && slot_used[i] && slot_rank[i] < r) slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  function automatic void lookup_and_update(input cache_op_t op, output bit produced,
                                            output lookup_t res);
    int s;
    int best;
    bit found;
    int unsigned lim;
    s = find_slot(op.key);
    produced = 1'b0;
    res.hit = 1'b0;
    res.read_value = '1;
    if (op.command == lru_kv_pkg::CMD_GET) begin
      produced = 1'b1;
      if (s >= 0) begin
        promote(s);
        res.hit = 1'b1;
        res.read_value = slot_val[s];
      end
      return;
    end
    if (s >= 0) begin
      slot_val[s] = op.value;
      promote(s);
      return;
    end
    lim = (cap_reg == 0) ? 1 : (cap_reg > NSLOT) ? NSLOT : cap_reg;
    if (used_count < lim) begin
      for (int i = 0; i < NSLOT; i++)
        if (!slot_used[i]) begin
          s = i;
          break;
        end
    end
    if (s >= 0) begin
      for (int i = 0; i < NSLOT; i++)
        if (slot_used[i]) slot_rank[i]++;
      slot_used[s] = 1'b1;
      slot_rank[s] = 0;
      used_count++;
    end else begin
      // Store full at the current capacity: replace the least recent entry.
      best = 0;
      found = 1'b0;
      for (int i = 0; i < NSLOT; i++)
        if (slot_used[i] && (!found || slot_rank[i] > slot_rank[best])) begin
          best = i;
          found = 1'b1;
        end
      s = best;
      promote(s);
    end
    slot_key[s] = op.key;
    slot_val[s] = op.value;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_reads.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sender: offers queued items, holds the payload while stalled.
  always @(posedge clk) begin : drive
    cache_op_t op;
    lookup_t res;
    bit produced;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        op.command = command;
        op.key = key;
        op.value = value;
        lookup_and_update(op, produced, res);
        accepted_cnt++;
        if (produced) begin
          pending_reads.push_back(res);
          get_cnt++;
          if (res.hit) hit_cnt++;
        end else begin
          put_cnt++;
        end
      end
      if (!in_valid || !in_stall) begin
        if (access_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          op = access_q.pop_front();
          command <= op.command;
          key <= op.key;
          value <= op.value;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started on request from the stimulus process.
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end
  end

  // Receiver: checks each result transfer against the oldest expectation.
  always @(posedge clk) begin : monitor
    lookup_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_reads.size() == 0) begin
          $error("unexpected result: hit=%0b read_value=%h", hit, read_value);
          err_cnt++;
        end else begin
          want = pending_reads.pop_front();
          if (hit !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, hit);
            err_cnt++;
          end
          if (read_value !== want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, read_value);
            err_cnt++;
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic push_op(input logic cmd, input logic [31:0] k, input logic [31:0] v);
    cache_op_t op;
    op.command = cmd;
    op.key = k;
    op.value = v;
    access_q.push_back(op);
    queued_cnt++;
  endtask

  // Waits until every item has been taken and every result has come back,
  // then lets the pipeline settle so that a trailing put is done too.
  task automatic drain();
    while (access_q.size() != 0 || accepted_cnt != queued_cnt || pending_reads.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [lru_kv_pkg::CAP_W-1:0] cap);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_ADDR;
    pwdata <= 32'(cap);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cap_reg = cap;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[lru_kv_pkg::CAP_W-1:0] !== cap) begin
      $error("capacity readback: expected %0d, actual %0d", cap,
             prdata[lru_kv_pkg::CAP_W-1:0]);
      err_cnt++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [lru_kv_pkg::CAP_W-1:0] phase_caps [NUM_PHASES];
    logic [31:0] key_pool [24];
    int pool_n;
    int eff;
    logic [31:0] k;
    phase_caps = '{5'd3, 5'd0, 5'd31, 5'd1, 5'd8, 5'd16, 5'd20, 5'd12};
    for (int i = 0; i < NSLOT; i++) begin
      slot_used[i] = 1'b0;
      slot_rank[i] = 0;
      slot_key[i] = '0;
      slot_val[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty-store miss, extreme keys and values, a hit that
    // returns all ones, a miss, and an update of an existing key.
    push_op(lru_kv_pkg::CMD_GET, 32'h0000_0000, 32'h0);
    push_op(lru_kv_pkg::CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    push_op(lru_kv_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    push_op(lru_kv_pkg::CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(lru_kv_pkg::CMD_PUT, 32'h0000_0000, 32'h0000_0000);
    push_op(lru_kv_pkg::CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    push_op(lru_kv_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0);
    push_op(lru_kv_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0);
    push_op(lru_kv_pkg::CMD_GET, 32'h0000_0000, 32'h0);
    push_op(lru_kv_pkg::CMD_GET, 32'h0000_0001, 32'h0);
    push_op(lru_kv_pkg::CMD_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    push_op(lru_kv_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h0);
    push_op(lru_kv_pkg::CMD_GET, 32'h8000_0000, 32'h0);
    drain();

    // Each phase starts from the store the last one left, so lowering the
    // capacity below the number of valid entries is exercised on the way.
    for (int p = 0; p < NUM_PHASES; p++) begin
      cfg_write(phase_caps[p]);
      case (p % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 79;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 79;
        end
        default: begin
          gap_pct = 31;
          stall_pct = 31;
        end
      endcase
      eff = (phase_caps[p] == 0) ? 1 : (phase_caps[p] > NSLOT) ? NSLOT : phase_caps[p];
      pool_n = eff + $urandom_range(0, 6);
      if (pool_n > 24) pool_n = 24;
      foreach (key_pool[i]) key_pool[i] = $urandom();
      if ($urandom_range(0, 1)) key_pool[0] = 32'h8000_0000;
      if ($urandom_range(0, 1)) key_pool[pool_n - 1] = 32'h7FFF_FFFF;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        k = ($urandom_range(0, 99) < 90) ? key_pool[$urandom_range(0, pool_n - 1)]
                                          : $urandom();
        push_op(($urandom_range(0, 99) < 55) ? lru_kv_pkg::CMD_PUT : lru_kv_pkg::CMD_GET,
                k, $urandom());
      end
      if (p == 4) hold_req++;
      drain();
    end

    $display("covered %0d transfers in %0d capacity settings: %0d puts, %0d gets (%0d hits)",
             accepted_cnt, NUM_PHASES + 1, put_cnt, get_cnt, hit_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
